// ===== design/wildcard_line_matcher_macros.svh =====
// Assertion macros used by the wildcard line matcher checker
`ifndef WILDCARD_LINE_MATCHER_MACROS_SVH
`define WILDCARD_LINE_MATCHER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define WLM_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define WLM_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== design/wlm_pkg.sv =====
// Types, constants and helpers shared by the wildcard line matcher modules
package wlm_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int MATCH_MAX_DEF   = 32;

    localparam logic [7:0] CH_HASH     = 8'h23;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_UPPER_A  = 8'd65;
    localparam logic [7:0] CH_UPPER_Z  = 8'd90;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    localparam int APB_AW = 6;
    localparam int APB_DW = 64;

    localparam logic [2:0] REG_PAT_LO  = 3'd0;
    localparam logic [2:0] REG_PAT_HI  = 3'd1;
    localparam logic [2:0] REG_PAT_LEN = 3'd2;
    localparam logic [2:0] REG_ICASE   = 3'd3;
    localparam logic [2:0] REG_WILD    = 3'd4;
    localparam logic [2:0] REG_REPORT  = 3'd5;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic [7:0] text_char;
        logic       line_end;
    } text_item_t;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] out_char;
        logic       run_last;
        logic       line_hit;
        logic       truncated;
    } result_item_t;

    typedef struct packed {
        logic [63:0] pattern_high_chars;
        logic [63:0] pattern_low_chars;
        logic [4:0]  pattern_length;
        logic        ignore_case;
        logic        wildcards_on;
        logic        report_matches;
    } cfg_t;

    function automatic logic [7:0] fold_char(input logic [7:0] c, input logic icase);
        logic [7:0] r;
        r = c;
        if (icase && c >= CH_UPPER_A && c <= CH_UPPER_Z)
            r = c + CASE_OFFSET;
        return r;
    endfunction

endpackage

// ===== design/wlm_cfg.sv =====
// APB configuration registers of the wildcard line matcher
module wlm_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wlm_pkg::APB_AW-1:0]  paddr,
    input  logic [wlm_pkg::APB_DW-1:0]  pwdata,
    output logic [wlm_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output wlm_pkg::cfg_t               cfg
);
    import wlm_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[APB_AW-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_low_chars  <= '0;
            cfg_reg.pattern_high_chars <= '0;
            cfg_reg.pattern_length     <= 5'd1;
            cfg_reg.ignore_case        <= 1'b0;
            cfg_reg.wildcards_on       <= 1'b0;
            cfg_reg.report_matches     <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_PAT_LO:  cfg_reg.pattern_low_chars  <= pwdata;
                REG_PAT_HI:  cfg_reg.pattern_high_chars <= pwdata;
                REG_PAT_LEN: cfg_reg.pattern_length     <= pwdata[4:0];
                REG_ICASE:   cfg_reg.ignore_case        <= pwdata[0];
                REG_WILD:    cfg_reg.wildcards_on       <= pwdata[0];
                REG_REPORT:  cfg_reg.report_matches     <= pwdata[0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PAT_LO:  prdata = cfg_reg.pattern_low_chars;
            REG_PAT_HI:  prdata = cfg_reg.pattern_high_chars;
            REG_PAT_LEN: prdata = {59'd0, cfg_reg.pattern_length};
            REG_ICASE:   prdata = {63'd0, cfg_reg.ignore_case};
            REG_WILD:    prdata = {63'd0, cfg_reg.wildcards_on};
            REG_REPORT:  prdata = {63'd0, cfg_reg.report_matches};
            default:     prdata = '0;
        endcase
    end

endmodule

// ===== design/wlm_core.sv =====
// Matching sequencer with the match-run buffer memory and the result register
module wlm_core #(
    parameter int PATTERN_MAX = wlm_pkg::PATTERN_MAX_DEF,
    parameter int MATCH_MAX   = wlm_pkg::MATCH_MAX_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wlm_pkg::cfg_t         cfg,
    input  logic                  text_valid,
    output logic                  text_stall,
    input  wlm_pkg::text_item_t   text_item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output wlm_pkg::result_item_t result_item
);
    import wlm_pkg::*;

    localparam int PW = $clog2(PATTERN_MAX + 1);
    localparam int CW = $clog2(MATCH_MAX + 1);
    localparam int AW = $clog2(MATCH_MAX);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_JUDGE = 3'd1;
    localparam logic [2:0] S_POST  = 3'd2;
    localparam logic [2:0] S_ERD   = 3'd3;
    localparam logic [2:0] S_EWR   = 3'd4;
    localparam logic [2:0] S_VERD  = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic          phase_reg, phase_next;
    logic [7:0]    cur_char_reg, cur_char_next;
    logic          cur_end_reg, cur_end_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [CW-1:0] count_reg, count_next;
    logic          overflow_reg, overflow_next;
    logic [7:0]    held_char_reg, held_char_next;
    logic          held_valid_reg, held_valid_next;
    logic          hit_seen_reg, hit_seen_next;
    logic [CW-1:0] emit_idx_reg, emit_idx_next;
    logic [CW-1:0] emit_num_reg, emit_num_next;
    logic          emit_trunc_reg, emit_trunc_next;
    logic          out_valid_reg, out_valid_next;
    result_item_t  out_item_reg, out_item_next;
    logic [7:0]    rdata_reg;

    logic [7:0]    run_mem [MATCH_MAX];

    logic [4:0]    len_sat;
    logic [4:0]    pos5, pos_nx5;
    logic [127:0]  pat_all;
    logic [7:0]    p_cur, p_nxt;
    logic [7:0]    j_char;
    logic          j_has_la, j_act, skip, at_end, lit, hash, next_ok, room;
    logic          out_free, emit_last, mem_we;

    assign len_sat  = (cfg.pattern_length > 5'(PATTERN_MAX)) ? 5'(PATTERN_MAX)
                                                              : cfg.pattern_length;
    assign pos5     = 5'(pos_reg);
    assign pos_nx5  = pos5 + 5'd1;
    assign pat_all  = {cfg.pattern_high_chars, cfg.pattern_low_chars};
    assign p_cur    = pat_all[{pos5[3:0], 3'b000} +: 8];
    assign p_nxt    = pat_all[{pos_nx5[3:0], 3'b000} +: 8];
    assign j_char   = phase_reg ? cur_char_reg : held_char_reg;
    assign j_has_la = !phase_reg;
    assign j_act    = phase_reg || held_valid_reg;
    assign skip     = hit_seen_reg && !cfg.report_matches;
    assign at_end   = pos5 >= len_sat;
    assign lit      = (fold_char(j_char, cfg.ignore_case) == fold_char(p_cur, cfg.ignore_case))
                      || (cfg.wildcards_on && p_cur == CH_DOT);
    assign hash     = cfg.wildcards_on && p_cur == CH_HASH;
    assign next_ok  = (pos_nx5 < len_sat)
                      ? (j_has_la && fold_char(cur_char_reg, cfg.ignore_case)
                                     == fold_char(p_nxt, cfg.ignore_case))
                      : !j_has_la;
    assign room     = count_reg < CW'(MATCH_MAX);
    assign out_free = !out_valid_reg || !result_stall;
    assign emit_last = (emit_idx_reg + CW'(1)) == emit_num_reg;
    assign mem_we   = (state_reg == S_JUDGE) && j_act && !skip && !at_end
                      && (lit || hash) && room;

    assign text_stall   = state_reg != S_IDLE;
    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        cur_char_next   = cur_char_reg;
        cur_end_next    = cur_end_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        overflow_next   = overflow_reg;
        held_char_next  = held_char_reg;
        held_valid_next = held_valid_reg;
        hit_seen_next   = hit_seen_reg;
        emit_idx_next   = emit_idx_reg;
        emit_num_next   = emit_num_reg;
        emit_trunc_next = emit_trunc_reg;
        out_valid_next  = out_valid_reg && result_stall;
        out_item_next   = out_item_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (text_valid)
                begin
                    cur_char_next = text_item.text_char;
                    cur_end_next  = text_item.line_end;
                    phase_next    = 1'b0;
                    state_next    = S_JUDGE;
                end
            end
            S_JUDGE:
            begin
                state_next = S_POST;
                if (j_act && !skip)
                begin
                    if (at_end)
                    begin
                        hit_seen_next = 1'b1;
                        pos_next      = '0;
                        count_next    = '0;
                        overflow_next = 1'b0;
                        if (cfg.report_matches && count_reg != '0)
                        begin
                            emit_idx_next   = '0;
                            emit_num_next   = count_reg;
                            emit_trunc_next = overflow_reg;
                            state_next      = S_ERD;
                        end
                    end
                    else if (lit || hash)
                    begin
                        if (room)
                            count_next = count_reg + CW'(1);
                        else
                            overflow_next = 1'b1;
                        if (lit || next_ok)
                            pos_next = pos_reg + PW'(1);
                    end
                    else
                    begin
                        pos_next      = '0;
                        count_next    = '0;
                        overflow_next = 1'b0;
                    end
                end
            end
            S_ERD:
            begin
                state_next = S_EWR;
            end
            S_EWR:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_item_next.out_kind  = KIND_CHAR;
                    out_item_next.out_char  = rdata_reg;
                    out_item_next.run_last  = emit_last;
                    out_item_next.line_hit  = 1'b0;
                    out_item_next.truncated = emit_trunc_reg;
                    if (emit_last)
                        state_next = S_POST;
                    else
                    begin
                        emit_idx_next = emit_idx_reg + CW'(1);
                        state_next    = S_ERD;
                    end
                end
            end
            S_POST:
            begin
                if (phase_reg)
                    state_next = S_VERD;
                else if (!cur_end_reg)
                begin
                    held_char_next  = cur_char_reg;
                    held_valid_next = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    phase_next = 1'b1;
                    state_next = S_JUDGE;
                end
            end
            S_VERD:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_item_next.out_kind  = KIND_VERDICT;
                    out_item_next.out_char  = 8'd0;
                    out_item_next.run_last  = 1'b1;
                    out_item_next.line_hit  = hit_seen_reg;
                    out_item_next.truncated = 1'b0;
                    pos_next        = '0;
                    count_next      = '0;
                    overflow_next   = 1'b0;
                    held_char_next  = 8'd0;
                    held_valid_next = 1'b0;
                    hit_seen_next   = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= 1'b0;
            cur_end_reg    <= 1'b0;
            pos_reg        <= '0;
            count_reg      <= '0;
            overflow_reg   <= 1'b0;
            held_char_reg  <= 8'd0;
            held_valid_reg <= 1'b0;
            hit_seen_reg   <= 1'b0;
            emit_idx_reg   <= '0;
            emit_num_reg   <= '0;
            emit_trunc_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            cur_end_reg    <= cur_end_next;
            pos_reg        <= pos_next;
            count_reg      <= count_next;
            overflow_reg   <= overflow_next;
            held_char_reg  <= held_char_next;
            held_valid_reg <= held_valid_next;
            hit_seen_reg   <= hit_seen_next;
            emit_idx_reg   <= emit_idx_next;
            emit_num_reg   <= emit_num_next;
            emit_trunc_reg <= emit_trunc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_char_reg <= cur_char_next;
        out_item_reg <= out_item_next;
    end

    // run buffer: one write port at the fill count, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            run_mem[count_reg[AW-1:0]] <= j_char;
        if (state_reg == S_ERD)
            rdata_reg <= run_mem[emit_idx_reg[AW-1:0]];
    end

endmodule

// ===== design/wildcard_line_matcher.sv =====
// Top level of the wildcard line matcher
//
//   channel   direction  handshake                   payload
//   text      in         text_valid / text_stall     text_item   (wlm_pkg::text_item_t)
//   result    out        result_valid / result_stall result_item (wlm_pkg::result_item_t)
//   config    in         APB psel/penable/pready     64-bit registers at 8*index
//
// One item at a time: a character inside a line steps S_IDLE, S_JUDGE, S_POST; a line
// end adds a second S_JUDGE/S_POST for itself and S_VERD; each emitted match character
// steps S_ERD (the single read port of the run buffer) and S_EWR, and a stalled result
// register holds S_EWR or S_VERD. rst_n clears all line state at once; the run buffer
// needs no clearing. Input is stalled whenever an item is in progress.
module wildcard_line_matcher #(
    parameter int PATTERN_MAX = wlm_pkg::PATTERN_MAX_DEF,
    parameter int MATCH_MAX   = wlm_pkg::MATCH_MAX_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        text_valid,
    output logic                        text_stall,
    input  wlm_pkg::text_item_t         text_item,
    output logic                        result_valid,
    input  logic                        result_stall,
    output wlm_pkg::result_item_t       result_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wlm_pkg::APB_AW-1:0]  paddr,
    input  logic [wlm_pkg::APB_DW-1:0]  pwdata,
    output logic [wlm_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import wlm_pkg::*;

    cfg_t cfg;

    wlm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wlm_core #(
        .PATTERN_MAX (PATTERN_MAX),
        .MATCH_MAX   (MATCH_MAX)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text_item    (text_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

// ===== design/wlm_checker.sv =====
// Port-level assertions for the wildcard line matcher, bound to the top level
`include "wildcard_line_matcher_macros.svh"

module wlm_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  text_valid,
    input logic                  text_stall,
    input logic                  result_valid,
    input logic                  result_stall,
    input wlm_pkg::result_item_t result_item
);
    import wlm_pkg::*;

    `WLM_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result_item), "stalled result item changed")
    `WLM_ASSERT_NOW(a_verdict_form, result_valid && result_item.out_kind == KIND_VERDICT, result_item.run_last && result_item.out_char == 8'd0 && !result_item.truncated, "malformed verdict item")
    `WLM_ASSERT_NOW(a_char_no_hit, result_valid && result_item.out_kind == KIND_CHAR, !result_item.line_hit, "character item carries line hit")
    `WLM_ASSERT_NEXT(a_busy_after_accept, text_valid && !text_stall, text_stall, "second item taken while one is in progress")

endmodule

bind wildcard_line_matcher wlm_checker u_wlm_checker (.*);

// ===== verif/wildcard_line_matcher_tb.sv =====
// Self-checking testbench for the wildcard line matcher: directed lines, then random traffic
`timescale 1ns / 100ps

module wildcard_line_matcher_tb;
    import wlm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PAT_CAP     = PATTERN_MAX_DEF;
    localparam int RUN_CAP     = MATCH_MAX_DEF;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                text_valid;
    logic                text_stall;
    text_item_t          text_item;
    logic                result_valid;
    logic                result_stall = 1'b0;
    result_item_t        result_item;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // shadow configuration
    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [4:0]  pat_len;
    logic        icase;
    logic        wild;
    logic        report;

    // line state of the matcher model
    int          pos;
    logic [7:0]  run_chars [RUN_CAP];
    int          run_len;
    logic        run_ovf;
    logic [7:0]  held_char;
    logic        held_valid;
    logic        hit_seen;

    result_item_t awaited_results[$];
    result_item_t want;

    int errors;
    int cycles;
    int items_sent;
    int lines_sent;
    int chars_seen;
    int verdicts_seen;
    int hits_seen;
    int cut_seen;
    int setups;
    int send_idle_pct;
    int recv_stall_pct;

    wildcard_line_matcher i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text_item    (text_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: cycle limit reached, %0d results outstanding", $time,
                     awaited_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // ---------------- matcher model ----------------

    function automatic int eff_pat_len();
        return (pat_len > PAT_CAP) ? PAT_CAP : int'(pat_len);
    endfunction

    function automatic logic [7:0] pat_byte(int k);
        int j;
        j = k & 15;
        if (j < 8)
            return pat_lo[8*j +: 8];
        return pat_hi[8*(j-8) +: 8];
    endfunction

    function automatic logic [7:0] fold_ch(logic [7:0] c);
        if (icase && c >= CH_UPPER_A && c <= CH_UPPER_Z)
            return c + CASE_OFFSET;
        return c;
    endfunction

    function automatic void clear_run();
        pos = 0;
        run_len = 0;
        run_ovf = 1'b0;
    endfunction

    function automatic void add_to_run(logic [7:0] c);
        if (run_len < RUN_CAP)
        begin
            run_chars[run_len] = c;
            run_len++;
        end
        else
            run_ovf = 1'b1;
    endfunction

    function automatic void push_result(logic kind, logic [7:0] c, logic last, logic hit,
                                        logic cut);
        result_item_t r;
        r.out_kind = kind;
        r.out_char = c;
        r.run_last = last;
        r.line_hit = hit;
        r.truncated = cut;
        awaited_results.push_back(r);
    endfunction

    function automatic void judge_char(logic [7:0] c, logic has_la, logic [7:0] la);
        int len;
        int k;
        logic [7:0] p;
        logic next_ok;
        len = eff_pat_len();
        if (hit_seen && !report)
            return;
        if (pos >= len)
        begin
            hit_seen = 1'b1;
            if (report)
                for (k = 0; k < run_len; k++)
                    push_result(KIND_CHAR, run_chars[k], k + 1 == run_len, 1'b0, run_ovf);
            clear_run();
            return;
        end
        p = pat_byte(pos);
        if (fold_ch(c) == fold_ch(p) || (wild && p == CH_DOT))
        begin
            add_to_run(c);
            pos++;
        end
        else if (wild && p == CH_HASH)
        begin
            if (pos + 1 < len)
                next_ok = has_la && fold_ch(la) == fold_ch(pat_byte(pos + 1));
            else
                next_ok = !has_la;
            add_to_run(c);
            if (next_ok)
                pos++;
        end
        else
            clear_run();
    endfunction

    function automatic void predict_text_item(text_item_t it);
        if (held_valid)
            judge_char(held_char, 1'b1, it.text_char);
        if (!it.line_end)
        begin
            held_char = it.text_char;
            held_valid = 1'b1;
            return;
        end
        judge_char(it.text_char, 1'b0, 8'h00);
        push_result(KIND_VERDICT, 8'h00, 1'b1, hit_seen, 1'b0);
        clear_run();
        held_char = 8'h00;
        held_valid = 1'b0;
        hit_seen = 1'b0;
    endfunction

    // ---------------- result checker ----------------

    function automatic void check_field(string field, logic [7:0] exp_v, logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, exp_v, act_v);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, got %h", $time, result_item);
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("out_kind", 8'(want.out_kind), 8'(result_item.out_kind));
                check_field("out_char", want.out_char, result_item.out_char);
                check_field("run_last", 8'(want.run_last), 8'(result_item.run_last));
                check_field("line_hit", 8'(want.line_hit), 8'(result_item.line_hit));
                check_field("truncated", 8'(want.truncated), 8'(result_item.truncated));
                if (want.out_kind == KIND_VERDICT)
                begin
                    verdicts_seen++;
                    if (want.line_hit)
                        hits_seen++;
                end
                else
                begin
                    chars_seen++;
                    if (want.truncated)
                        cut_seen++;
                end
            end
        end
    end

    // ---------------- drivers ----------------

    task automatic write_reg(logic [2:0] idx, logic [63:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_PAT_LO:  pat_lo = v;
            REG_PAT_HI:  pat_hi = v;
            REG_PAT_LEN: pat_len = v[4:0];
            REG_ICASE:   icase = v[0];
            REG_WILD:    wild = v[0];
            REG_REPORT:  report = v[0];
            default: ;
        endcase
    endtask

    task automatic set_pattern(logic [63:0] lo, logic [63:0] hi, logic [4:0] len,
                               logic ic, logic wc, logic rp);
        write_reg(REG_PAT_LO, lo);
        write_reg(REG_PAT_HI, hi);
        write_reg(REG_PAT_LEN, {59'd0, len});
        write_reg(REG_ICASE, {63'd0, ic});
        write_reg(REG_WILD, {63'd0, wc});
        write_reg(REG_REPORT, {63'd0, rp});
        setups++;
    endtask

    task automatic send_item(logic [7:0] c, logic e);
        int gap;
        text_item_t it;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.text_char = c;
        it.line_end = e;
        text_valid <= 1'b1;
        text_item <= it;
        do @(posedge clk); while (text_stall);
        predict_text_item(it);
        items_sent++;
        if (e)
            lines_sent++;
    endtask

    task automatic send_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_item(s[i], i == s.len() - 1);
    endtask

    // sender holds off until every awaited result is back and the block is idle
    task automatic drain_results();
        text_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(8))
            0: return "a";
            1: return "b";
            2: return "c";
            3: return "A";
            4: return "B";
            5: return CH_DOT;
            6: return CH_HASH;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // ---------------- tests ----------------

    task automatic test_reset_pattern();
        // reset pattern is a single zero byte, literal, line mode
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b1);
        drain_results();
    endtask

    task automatic test_wildcard_report();
        set_pattern(64'h7A23_2E61, 64'd0, 5'd4, 1'b0, 1'b1, 1'b1);   // "a.#z"
        send_text("xa?qqzzK");
        drain_results();
    endtask

    task automatic test_folded_literals();
        set_pattern(64'h41_2E23, 64'd0, 5'd3, 1'b1, 1'b0, 1'b0);     // "#.A"
        send_text("#.ab");
        send_text("#.a");
        drain_results();
    endtask

    task automatic test_trailing_hash();
        set_pattern(64'h2362, {64{1'b1}}, 5'd2, 1'b0, 1'b1, 1'b1);   // "b#"
        send_text("bcd");
        drain_results();
    endtask

    task automatic test_empty_pattern();
        set_pattern(64'd0, 64'd0, 5'd0, 1'b0, 1'b0, 1'b1);
        send_text("xy");
        drain_results();
        write_reg(REG_REPORT, 64'd0);
        send_text("q");
        drain_results();
    endtask

    task automatic test_run_overflow();
        int i;
        set_pattern(64'h7A_2361, 64'd0, 5'd3, 1'b0, 1'b1, 1'b1);     // "a#z"
        send_item("a", 1'b0);
        for (i = 0; i < 36; i++)
            send_item("x", 1'b0);
        send_item("z", 1'b0);
        send_item("y", 1'b1);
        drain_results();
    endtask

    task automatic randomize_setup();
        int k;
        int flavor;
        logic [7:0] b;
        logic [4:0] len;
        logic [63:0] lo;
        logic [63:0] hi;
        case ($urandom_range(9))
            0: len = 5'd0;
            1: len = 5'd16;
            2: len = 5'd31;
            3: len = 5'($urandom_range(17, 30));
            default: len = 5'($urandom_range(1, 5));
        endcase
        flavor = $urandom_range(9);
        for (k = 0; k < PAT_CAP; k++)
        begin
            b = (flavor == 0) ? 8'hFF : (flavor == 1) ? 8'h00 : pick_char();
            if (k < 8)
                lo[8*k +: 8] = b;
            else
                hi[8*(k-8) +: 8] = b;
        end
        set_pattern(lo, hi, len, 1'($urandom_range(1)), $urandom_range(2) != 0,
                    1'($urandom_range(1)));
    endtask

    task automatic send_random_line();
        logic [7:0] chars[$];
        logic [7:0] p;
        int n;
        int k;
        int fill;
        if ($urandom_range(3) != 0)
        begin
            n = $urandom_range(2);
            repeat (n) chars.push_back(pick_char());
            for (k = 0; k < eff_pat_len(); k++)
            begin
                p = pat_byte(k);
                if (wild && p == CH_HASH)
                begin
                    fill = ($urandom_range(11) == 0) ? $urandom_range(34, 40)
                                                      : $urandom_range(1, 3);
                    repeat (fill) chars.push_back(pick_char());
                end
                else if (wild && p == CH_DOT)
                    chars.push_back(pick_char());
                else if (icase && $urandom_range(1) && p >= "a" && p <= "z")
                    chars.push_back(p - CASE_OFFSET);
                else
                    chars.push_back(p);
            end
            n = $urandom_range(1, 2);
            repeat (n) chars.push_back(pick_char());
        end
        else
        begin
            n = $urandom_range(1, 8);
            repeat (n) chars.push_back(8'($urandom_range(255)));
        end
        for (k = 0; k < chars.size(); k++)
            send_item(chars[k], k == chars.size() - 1);
    endtask

    task automatic test_random_traffic(int send_pct, int stall_pct);
        int start;
        int lines;
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        start = items_sent;
        lines = 0;
        while (items_sent - start < 70)
        begin
            if (lines % 4 == 0)
            begin
                drain_results();
                randomize_setup();
            end
            send_random_line();
            lines++;
        end
        drain_results();
    endtask

    initial
    begin
        pat_lo = 64'd0;
        pat_hi = 64'd0;
        pat_len = 5'd1;
        icase = 1'b0;
        wild = 1'b0;
        report = 1'b0;
        clear_run();
        held_char = 8'h00;
        held_valid = 1'b0;
        hit_seen = 1'b0;
        errors = 0;
        cycles = 0;
        items_sent = 0;
        lines_sent = 0;
        chars_seen = 0;
        verdicts_seen = 0;
        hits_seen = 0;
        cut_seen = 0;
        setups = 0;
        send_idle_pct = 12;
        recv_stall_pct = 46;

        rst_n <= 1'b0;
        text_valid <= 1'b0;
        text_item <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_pattern();
        test_wildcard_report();
        test_folded_literals();
        test_trailing_hash();
        test_empty_pattern();
        test_run_overflow();
        test_random_traffic(12, 46);
        test_random_traffic(46, 12);
        test_random_traffic(0, 0);

        drain_results();
        repeat (30) @(posedge clk);
        if (awaited_results.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, awaited_results.size());
        end

        $display("Sent %0d text items in %0d lines over %0d pattern setups.",
                 items_sent, lines_sent, setups);
        $display("Checked %0d match characters (%0d cut), %0d verdicts (%0d hits).",
                 chars_seen, cut_seen, verdicts_seen, hits_seen);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== wildcard_line_matcher.f =====
+incdir+design
design/wlm_pkg.sv
design/wlm_cfg.sv
design/wlm_core.sv
design/wildcard_line_matcher.sv
design/wlm_checker.sv
verif/wildcard_line_matcher_tb.sv
